FILE: hdl/rmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared opcodes, constants and controller/datapath interface types for the
// running mean / variance / min / max block.
// ----------------------------------------------------------------------------
package rmv_pkg;

  // opcodes carried by an input item
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // variance stays zero below this many samples
  localparam int unsigned MIN_COUNT_FOR_VAR = 2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;         // item accepted: add sample or clear
    logic div_step;     // one restoring divider step
    logic mul_step;     // one shift-add multiplier step
    logic mean_upd;     // write the new mean from the quotient
    logic mula_load;    // start |d1| * |d2|
    logic mulb_load;    // keep m2, start spread * (n - 1)
    logic acc_chk;      // form the sum, check range, start the variance divide
    logic spread_upd;   // write the variance quotient
    logic out_load;     // copy the statistics to the result registers
  } rmv_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic var_skip;     // count below the variance minimum
    logic acc_sat;      // variance quotient would not fit
  } rmv_stat_t;

endpackage
`default_nettype wire

FILE: hdl/running_mean_variance_minmax.sv
`default_nettype none
// ----------------------------------------------------------------------------
// running_mean_variance_minmax
// Running count, mean, population variance, min, max and last sample of a
// stream of signed samples, with a clear command.
// ----------------------------------------------------------------------------
// One item at a time. A clear item goes straight to the result state.
// An add item runs the mean divide, then the variance multiplies and
// divide; the first sample after a clear skips the variance.
// The time is set by one bit-serial restoring divider, used for the mean step
// and the variance divide, and one shift-add multiplier, used for |d1|*|d2|
// and spread*(n-1), each retiring one bit a cycle. The result sits in an
// output register, so the next item is accepted while a result waits.
// The mean is signed Q(SAMPLE_BITS).(FRAC_BITS), the variance unsigned
// Q(2*SAMPLE_BITS).(FRAC_BITS) and saturates at all ones; the count saturates.
module running_mean_variance_minmax #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 opcode_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]   mean_o,
  output logic [2*SAMPLE_BITS+FRAC_BITS-1:0]        spread_o,
  output logic signed [SAMPLE_BITS-1:0]             smallest_o,
  output logic signed [SAMPLE_BITS-1:0]             largest_o,
  output logic [COUNT_BITS-1:0]                     sample_count_o,
  output logic signed [SAMPLE_BITS-1:0]             latest_o,
  output logic                                      empty_res_o
);

  rmv_pkg::rmv_cmd_t  cmd;
  rmv_pkg::rmv_stat_t stat;

  rmv_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rmv_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (opcode_i),
    .sample_i       (sample_i),
    .mean_o         (mean_o),
    .spread_o       (spread_o),
    .smallest_o     (smallest_o),
    .largest_o      (largest_o),
    .sample_count_o (sample_count_o),
    .latest_o       (latest_o),
    .empty_res_o    (empty_res_o)
  );

endmodule
`default_nettype wire

FILE: hdl/rmv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_ctrl
// Sequencer for one item: handshakes, step counter for the shared divider and
// multiplier, and the result valid flag.
// ----------------------------------------------------------------------------
module rmv_ctrl #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              opcode_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rmv_pkg::rmv_cmd_t      cmd_o,
  input  wire rmv_pkg::rmv_stat_t stat_i
);

  localparam int unsigned DW    = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int unsigned SW    = 2 * SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(SW + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV1 = 4'd1;
  localparam logic [3:0] ST_MEAN = 4'd2;
  localparam logic [3:0] ST_D2   = 4'd3;
  localparam logic [3:0] ST_MULA = 4'd4;
  localparam logic [3:0] ST_M2   = 4'd5;
  localparam logic [3:0] ST_MULB = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;
  localparam logic [3:0] ST_DIV2 = 4'd8;
  localparam logic [3:0] ST_SPR  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             last;

  assign last = (cnt_q == '0);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          cnt_d      = CNT_W'(DW - 1);
          state_d    = (opcode_i == rmv_pkg::OP_CLEAR) ? ST_FIN : ST_DIV1;
        end
      end
      ST_DIV1: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (last) state_d = ST_MEAN;
      end
      ST_MEAN: begin
        cmd_o.mean_upd = 1'b1;
        state_d        = stat_i.var_skip ? ST_FIN : ST_D2;
      end
      ST_D2: begin
        cmd_o.mula_load = 1'b1;
        cnt_d           = CNT_W'(DW - 1);
        state_d         = ST_MULA;
      end
      ST_MULA: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (last) state_d = ST_M2;
      end
      ST_M2: begin
        cmd_o.mulb_load = 1'b1;
        cnt_d           = CNT_W'(COUNT_BITS - 1);
        state_d         = ST_MULB;
      end
      ST_MULB: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (last) state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_chk = 1'b1;
        cnt_d         = CNT_W'(SW - 1);
        state_d       = stat_i.acc_sat ? ST_FIN : ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (last) state_d = ST_SPR;
      end
      ST_SPR: begin
        cmd_o.spread_upd = 1'b1;
        state_d          = ST_FIN;
      end
      ST_FIN: begin
        // hold the finished item until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == rmv_pkg::OP_CLEAR) |=> state_q == ST_FIN)
    else $error("clear item did not go straight to the result state");

  a_div2_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV2 && last) |=> state_q == ST_SPR)
    else $error("variance divide did not end after its last step");

  a_mulb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULB) |-> cnt_q < CNT_W'(COUNT_BITS))
    else $error("multiplier step count out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=> state_q == ST_FIN)
    else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

FILE: hdl/rmv_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_dp
// Statistics registers, shared restoring divider, shared shift-add
// multiplier and the result registers.
// ----------------------------------------------------------------------------
module rmv_dp #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire rmv_pkg::rmv_cmd_t                      cmd_i,
  output rmv_pkg::rmv_stat_t                          stat_o,
  input  wire logic                                   opcode_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_i,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]     mean_o,
  output logic [2*SAMPLE_BITS+FRAC_BITS-1:0]          spread_o,
  output logic signed [SAMPLE_BITS-1:0]               smallest_o,
  output logic signed [SAMPLE_BITS-1:0]               largest_o,
  output logic [COUNT_BITS-1:0]                       sample_count_o,
  output logic signed [SAMPLE_BITS-1:0]               latest_o,
  output logic                                        empty_res_o
);

  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned C   = COUNT_BITS;
  localparam int unsigned MW  = S + F;
  localparam int unsigned SW  = 2 * S + F;
  localparam int unsigned DW  = MW + 1;
  localparam int unsigned EXT = (C > F + 2) ? C : F + 2;
  localparam int unsigned PW  = SW + EXT;
  localparam int unsigned AW  = PW + 1;
  localparam int unsigned HW  = AW - SW;
  localparam int unsigned LW  = (DW > C) ? DW : C;
  localparam int unsigned M2W = SW + 2;

  // statistics
  logic [MW-1:0] mean_q, mean_d;
  logic [SW-1:0] spread_q, spread_d;
  logic [S-1:0]  min_q, min_d, max_q, max_d, latest_q, latest_d;
  logic [C-1:0]  count_q, count_d;

  // working registers
  logic [SW-1:0]  dvd_q, dvd_d;
  logic [C-1:0]   rem_q, rem_d;
  logic           d1_neg_q, d1_neg_d;
  logic [DW-1:0]  a1_q, a1_d;
  logic [PW-1:0]  mcand_q, mcand_d, prod_q, prod_d;
  logic [LW-1:0]  mlr_q, mlr_d;
  logic [M2W-1:0] m2_q, m2_d;

  logic [DW-1:0] mean_ext, xs_in, xs_cur, d1, a1, d2, a2, quo, delta, nm;
  logic [C:0]    trial, trial_sub;
  logic          ge;
  logic [AW-1:0] acc;
  logic [HW-1:0] acc_hi;
  logic          is_add;

  assign is_add   = (opcode_i == rmv_pkg::OP_ADD);
  assign mean_ext = {mean_q[MW-1], mean_q};
  assign xs_in    = {sample_i[S-1], sample_i, {F{1'b0}}};
  assign xs_cur   = {latest_q[S-1], latest_q, {F{1'b0}}};

  assign d1 = xs_in - mean_ext;
  assign a1 = d1[DW-1] ? DW'(~d1 + DW'(1)) : d1;
  assign d2 = xs_cur - mean_ext;
  assign a2 = d2[DW-1] ? DW'(~d2 + DW'(1)) : d2;

  // truncating mean step: quotient of |d1| / n carries the sign of d1
  assign quo   = dvd_q[DW-1:0];
  assign delta = d1_neg_q ? DW'(~quo + DW'(1)) : quo;
  assign nm    = mean_ext + delta;

  // restoring divider step
  assign trial     = {rem_q, dvd_q[SW-1]};
  assign trial_sub = trial - {1'b0, count_q};
  assign ge        = (trial >= {1'b0, count_q});

  // (n-1)*var + m2, and whether the quotient by n overflows the field
  assign acc    = {1'b0, prod_q} + AW'(m2_q);
  assign acc_hi = acc[AW-1:SW];

  assign stat_o.var_skip = (count_q < C'(rmv_pkg::MIN_COUNT_FOR_VAR));
  assign stat_o.acc_sat  = (acc_hi >= HW'(count_q));

  always_comb begin
    mean_d   = mean_q;
    spread_d = spread_q;
    min_d    = min_q;
    max_d    = max_q;
    latest_d = latest_q;
    count_d  = count_q;
    if (cmd_i.take) begin
      if (is_add) begin
        latest_d = sample_i;
        count_d  = (count_q != '1) ? count_q + C'(1) : count_q;
        if ($signed(sample_i) < $signed(min_q)) min_d = sample_i;
        if ($signed(sample_i) > $signed(max_q)) max_d = sample_i;
      end else begin
        mean_d   = '0;
        spread_d = '0;
        min_d    = {1'b0, {(S-1){1'b1}}};
        max_d    = {1'b1, {(S-1){1'b0}}};
        count_d  = '0;
        latest_d = '0;
      end
    end
    if (cmd_i.mean_upd) begin
      mean_d = nm[MW-1:0];
      if (stat_o.var_skip) spread_d = '0;
    end
    if (cmd_i.acc_chk && stat_o.acc_sat) spread_d = '1;
    if (cmd_i.spread_upd) spread_d = dvd_q;
  end

  always_comb begin
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    d1_neg_d = d1_neg_q;
    a1_d     = a1_q;
    mcand_d  = mcand_q;
    mlr_d    = mlr_q;
    prod_d   = prod_q;
    m2_d     = m2_q;
    priority if (cmd_i.take) begin
      d1_neg_d = d1[DW-1];
      a1_d     = a1;
      dvd_d    = {a1, {(SW-DW){1'b0}}};
      rem_d    = '0;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[SW-2:0], ge};
      rem_d = ge ? trial_sub[C-1:0] : trial[C-1:0];
    end else if (cmd_i.mula_load) begin
      mcand_d = PW'(a1_q);
      mlr_d   = LW'(a2);
      prod_d  = '0;
    end else if (cmd_i.mul_step) begin
      if (mlr_q[0]) prod_d = prod_q + mcand_q;
      mcand_d = {mcand_q[PW-2:0], 1'b0};
      mlr_d   = {1'b0, mlr_q[LW-1:1]};
    end else if (cmd_i.mulb_load) begin
      m2_d    = prod_q[F +: M2W];
      mcand_d = PW'(spread_q);
      mlr_d   = LW'(count_q - C'(1));
      prod_d  = '0;
    end else if (cmd_i.acc_chk) begin
      rem_d = acc_hi[C-1:0];
      dvd_d = acc[SW-1:0];
    end else begin
      dvd_d = dvd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q   <= '0;
      spread_q <= '0;
      min_q    <= {1'b0, {(S-1){1'b1}}};
      max_q    <= {1'b1, {(S-1){1'b0}}};
      count_q  <= '0;
      latest_q <= '0;
    end else begin
      mean_q   <= mean_d;
      spread_q <= spread_d;
      min_q    <= min_d;
      max_q    <= max_d;
      count_q  <= count_d;
      latest_q <= latest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    d1_neg_q <= d1_neg_d;
    a1_q     <= a1_d;
    mcand_q  <= mcand_d;
    mlr_q    <= mlr_d;
    prod_q   <= prod_d;
    m2_q     <= m2_d;
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_o         <= mean_q;
      spread_o       <= spread_q;
      smallest_o     <= min_q;
      largest_o      <= max_q;
      sample_count_o <= count_q;
      latest_o       <= latest_q;
      empty_res_o    <= (count_q == '0);
    end
  end

endmodule
`default_nettype wire
